@@ rtl/core/eavr_pkg.sv @@
// shared constants, types and tables for the euler-angle vector rotation block
`timescale 1ns / 1ps
`default_nettype none
package eavr_pkg;
  localparam int TRIG_BITS = 16;
  localparam int VEC_BITS = 32;
  localparam int FRAC = TRIG_BITS - 1;
  localparam int CORDIC_STEPS = (TRIG_BITS < 24) ? TRIG_BITS : 24;
  localparam int ANG_BITS = 16;
  localparam int IO_BITS = 32;
  localparam int ACC_BITS = 34;  // q30 cordic datapath with headroom
  localparam int Z_BITS = 33;
  localparam logic signed [ACC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;
  // product of entry and vector: entries stay within about +-2^(F+2)
  localparam int ENT_BITS = TRIG_BITS + 3;
  localparam int PROD_BITS = VEC_BITS + ENT_BITS;
  localparam int SUM_BITS = PROD_BITS + 2;

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef logic signed [ENT_BITS-1:0] ent_t;
  typedef logic signed [VEC_BITS-1:0] vec_t;

  typedef struct packed {
    trig_t sp; trig_t cp; trig_t sy; trig_t cy; trig_t sr; trig_t cr;
  } trig_set_t;

  typedef struct packed {
    logic [ANG_BITS-1:0] pitch;
    logic [ANG_BITS-1:0] yaw;
    logic [ANG_BITS-1:0] roll;
    logic [IO_BITS-1:0] vec_x;
    logic [IO_BITS-1:0] vec_y;
    logic [IO_BITS-1:0] vec_z;
  } in_beat_t;

  typedef struct packed {
    logic [IO_BITS-1:0] rot_x;
    logic [IO_BITS-1:0] rot_y;
    logic [IO_BITS-1:0] rot_z;
  } out_beat_t;

  function automatic logic signed [Z_BITS-1:0] atan_val(input int i);
    logic signed [Z_BITS-1:0] t;
    case (i)
      0: t = 33'sd536870912;  1: t = 33'sd316933406;  2: t = 33'sd167458907;
      3: t = 33'sd85004756;   4: t = 33'sd42667331;   5: t = 33'sd21354465;
      6: t = 33'sd10680862;   7: t = 33'sd5340245;    8: t = 33'sd2670163;
      9: t = 33'sd1335087;    10: t = 33'sd667544;    11: t = 33'sd333772;
      12: t = 33'sd166886;    13: t = 33'sd83443;     14: t = 33'sd41722;
      15: t = 33'sd20861;     16: t = 33'sd10430;     17: t = 33'sd5215;
      18: t = 33'sd2608;      19: t = 33'sd1304;      20: t = 33'sd652;
      21: t = 33'sd326;       22: t = 33'sd163;       default: t = 33'sd81;
    endcase
    return t;
  endfunction

  // rounded product of two trig-range values, f fraction bits
  function automatic ent_t pmul(input ent_t a, input ent_t b);
    logic signed [2*ENT_BITS-1:0] p;
    p = (2*ENT_BITS)'(a) * (2*ENT_BITS)'(b) + (2*ENT_BITS)'(1 <<< (FRAC - 1));
    return ENT_BITS'(p >>> FRAC);
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/eavr_stream_if.sv @@
// valid/ready stream interface
`timescale 1ns / 1ps
`default_nettype none
interface eavr_in_if;
  logic valid;
  logic ready;
  eavr_pkg::in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface eavr_out_if;
  logic valid;
  logic ready;
  eavr_pkg::out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/eavr_cordic.sv @@
// pipelined cordic sine/cosine for three angles, one rotation per stage
`timescale 1ns / 1ps
`default_nettype none
module eavr_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [3*eavr_pkg::ANG_BITS-1:0] angles,
  input  wire logic [3*eavr_pkg::VEC_BITS-1:0] vec_in,
  output logic out_valid,
  output eavr_pkg::trig_set_t trig,
  output logic [3*eavr_pkg::VEC_BITS-1:0] vec_out
);
  localparam int N = eavr_pkg::CORDIC_STEPS;
  localparam int A = eavr_pkg::ACC_BITS;
  localparam int Z = eavr_pkg::Z_BITS;

  logic [N:0] vld;
  logic signed [A-1:0] x [0:N][0:2];
  logic signed [A-1:0] y [0:N][0:2];
  logic signed [Z-1:0] z [0:N][0:2];
  logic [1:0] q [0:N][0:2];
  logic [3*eavr_pkg::VEC_BITS-1:0] vp [0:N];

  always_comb begin
    vld[0] = in_valid;
    vp[0] = vec_in;
    for (int k = 0; k < 3; k++) begin
      logic [eavr_pkg::ANG_BITS-1:0] a;
      logic [eavr_pkg::ANG_BITS-1:0] as;
      a = angles[(2-k)*eavr_pkg::ANG_BITS +: eavr_pkg::ANG_BITS];
      as = a + 16'd8192;
      q[0][k] = as[15:14];
      z[0][k] = (Z'(signed'({1'b0, as[13:0]})) - Z'(8192)) <<< 16;
      x[0][k] = eavr_pkg::CORDIC_GAIN;
      y[0][k] = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vp[i+1] <= vp[i];
        for (int k = 0; k < 3; k++) begin
          q[i+1][k] <= q[i][k];
          if (z[i][k] >= 0) begin
            x[i+1][k] <= x[i][k] - (y[i][k] >>> i);
            y[i+1][k] <= y[i][k] + (x[i][k] >>> i);
            z[i+1][k] <= z[i][k] - eavr_pkg::atan_val(i);
          end else begin
            x[i+1][k] <= x[i][k] + (y[i][k] >>> i);
            y[i+1][k] <= y[i][k] - (x[i][k] >>> i);
            z[i+1][k] <= z[i][k] + eavr_pkg::atan_val(i);
          end
        end
      end
    end
  end

  function automatic eavr_pkg::trig_t rsat(input logic signed [A-1:0] v);
    logic signed [A-1:0] r;
    logic signed [A-1:0] lim;
    r = (v + A'(1 <<< (29 - eavr_pkg::FRAC))) >>> (30 - eavr_pkg::FRAC);
    lim = A'(1) <<< (eavr_pkg::TRIG_BITS - 1);
    if (r > lim - 1) r = lim - 1;
    else if (r < -lim) r = -lim;
    return eavr_pkg::TRIG_BITS'(r);
  endfunction

  // final rounding and quadrant fold
  eavr_pkg::trig_t sn [0:2];
  eavr_pkg::trig_t cs [0:2];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eavr_pkg::trig_t c;
      eavr_pkg::trig_t s;
      c = rsat(x[N][k]);
      s = rsat(y[N][k]);
      case (q[N][k])
        2'd0: begin cs[k] = c; sn[k] = s; end
        2'd1: begin cs[k] = -s; sn[k] = c; end
        2'd2: begin cs[k] = -c; sn[k] = -s; end
        default: begin cs[k] = s; sn[k] = -c; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      trig <= '{sp: sn[0], cp: cs[0], sy: sn[1], cy: cs[1], sr: sn[2], cr: cs[2]};
      vec_out <= vp[N];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/eavr_matrix.sv @@
// rotation matrix build in two stages and three dot products in three stages
`timescale 1ns / 1ps
`default_nettype none
module eavr_matrix (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  eavr_pkg::trig_set_t trig,
  input  wire logic [3*eavr_pkg::VEC_BITS-1:0] vec_in,
  output logic out_valid,
  output eavr_pkg::out_beat_t res
);
  localparam int E = eavr_pkg::ENT_BITS;
  localparam int VB = eavr_pkg::VEC_BITS;
  localparam int PB = eavr_pkg::PROD_BITS;
  localparam int SB = eavr_pkg::SUM_BITS;

  logic [3:0] vld;
  // stage a: pair products
  eavr_pkg::ent_t sp_a, cp_a, sy_a, cy_a, sr_a, cr_a, crcy, crsy, srcy, srsy;
  logic [3*VB-1:0] v_a, v_b;
  eavr_pkg::ent_t m [0:2][0:2];
  logic signed [PB-1:0] pr [0:2][0:2];
  logic signed [SB-1:0] sm [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_a <= E'(trig.sp); cp_a <= E'(trig.cp);
      sy_a <= E'(trig.sy); cy_a <= E'(trig.cy);
      sr_a <= E'(trig.sr); cr_a <= E'(trig.cr);
      crcy <= eavr_pkg::pmul(E'(trig.cr), E'(trig.cy));
      crsy <= eavr_pkg::pmul(E'(trig.cr), E'(trig.sy));
      srcy <= eavr_pkg::pmul(E'(trig.sr), E'(trig.cy));
      srsy <= eavr_pkg::pmul(E'(trig.sr), E'(trig.sy));
      v_a <= vec_in;
      // matrix entries
      m[0][0] <= eavr_pkg::pmul(cp_a, cy_a);
      m[0][1] <= eavr_pkg::pmul(sp_a, srcy) - crsy;
      m[0][2] <= eavr_pkg::pmul(sp_a, crcy) + srsy;
      m[1][0] <= eavr_pkg::pmul(cp_a, sy_a);
      m[1][1] <= eavr_pkg::pmul(sp_a, srsy) + crcy;
      m[1][2] <= eavr_pkg::pmul(sp_a, crsy) - srcy;
      m[2][0] <= -sp_a;
      m[2][1] <= eavr_pkg::pmul(sr_a, cp_a);
      m[2][2] <= eavr_pkg::pmul(cr_a, cp_a);
      v_b <= v_a;
      // vector times entry products
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pr[r][c] <= PB'(signed'(v_b[(2-c)*VB +: VB])) * PB'(m[r][c]);
        end
      end
      // row sums with rounding; saturation is applied before the output register
      for (int r = 0; r < 3; r++) begin
        sm[r] <= SB'(pr[r][0]) + SB'(pr[r][1]) + SB'(pr[r][2])
                 + SB'(1 <<< (eavr_pkg::FRAC - 1));
      end
    end
  end

  logic signed [SB-1:0] sh [0:2];
  logic signed [SB-1:0] hi_lim;
  always_comb begin
    hi_lim = (SB'(1) <<< (VB - 1)) - SB'(1);
    for (int r = 0; r < 3; r++) begin
      sh[r] = sm[r] >>> eavr_pkg::FRAC;
      if (sh[r] > hi_lim) sh[r] = hi_lim;
      else if (sh[r] < -hi_lim - SB'(1)) sh[r] = -hi_lim - SB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[3];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.rot_x <= eavr_pkg::IO_BITS'(signed'(sh[0][VB-1:0]));
      res.rot_y <= eavr_pkg::IO_BITS'(signed'(sh[1][VB-1:0]));
      res.rot_z <= eavr_pkg::IO_BITS'(signed'(sh[2][VB-1:0]));
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/euler_angle_vector_rotation.sv @@
// top level: cordic pipeline, matrix and dot-product pipeline, output skid stage
// each input beat passes the cordic stages, the matrix pipeline and the output register
// throughput: one beat per cycle; the whole pipe advances together unless the
// output register is full and the sink stalls, then a one-beat skid absorbs it
// reset: synchronous rst clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module euler_angle_vector_rotation (
  input wire logic clk,
  input wire logic rst,
  eavr_in_if.sink in_ch,
  eavr_out_if.source out_ch
);
  logic en, c_valid, p_valid;
  eavr_pkg::trig_set_t trig;
  logic [3*eavr_pkg::VEC_BITS-1:0] vec_c;
  eavr_pkg::out_beat_t p_res;
  eavr_pkg::out_beat_t skid;
  logic skid_full;

  // pipe advances whenever the skid slot is empty
  assign en = !skid_full;
  assign in_ch.ready = en;

  eavr_cordic u_cordic (
    .clk, .rst, .en,
    .in_valid(in_ch.valid),
    .angles({in_ch.data.pitch, in_ch.data.yaw, in_ch.data.roll}),
    .vec_in({in_ch.data.vec_x[eavr_pkg::VEC_BITS-1:0],
             in_ch.data.vec_y[eavr_pkg::VEC_BITS-1:0],
             in_ch.data.vec_z[eavr_pkg::VEC_BITS-1:0]}),
    .out_valid(c_valid), .trig, .vec_out(vec_c)
  );

  eavr_matrix u_matrix (
    .clk, .rst, .en,
    .in_valid(c_valid), .trig, .vec_in(vec_c),
    .out_valid(p_valid), .res(p_res)
  );

  // output register plus skid beat
  logic out_valid;
  eavr_pkg::out_beat_t out_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_valid || out_ch.ready) begin
        if (skid_full) begin
          out_valid <= 1'b1;
          skid_full <= 1'b0;
        end else begin
          out_valid <= p_valid;
        end
      end else if (p_valid && en) begin
        skid_full <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!out_valid || out_ch.ready) begin
      out_data <= skid_full ? skid : p_res;
    end
    if (en) begin
      skid <= p_res;
    end
  end
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
endmodule
`default_nettype wire

@@ rtl/core/eavr_checker.sv @@
// port-level checker for the rotation block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module eavr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input eavr_pkg::out_beat_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    out_ready |=> in_ready)
    else $error("input stalled although sink took output");
endmodule

bind euler_angle_vector_rotation eavr_checker u_eavr_checker (
  .clk, .rst,
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
